@@ sv/mp3sbp_pkg.sv @@
// shared types and constants for the mp3 seek byte position block
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package mp3sbp_pkg;

  // request kinds
  localparam logic REQ_TOC  = 1'b0;
  localparam logic REQ_SEEK = 1'b1;

  // rate modes
  localparam logic [1:0] MODE_CBR = 2'd0;
  localparam logic [1:0] MODE_VBR = 2'd1;

  // configuration register indexes
  localparam logic [2:0] CFG_RATE_MODE    = 3'd0;
  localparam logic [2:0] CFG_TRACK_LEN    = 3'd1;
  localparam logic [2:0] CFG_FILE_BYTES   = 3'd2;
  localparam logic [2:0] CFG_BYTES_FRAME  = 3'd3;
  localparam logic [2:0] CFG_MS_FRAME     = 3'd4;
  localparam logic [2:0] CFG_TAIL_TAG     = 3'd5;
  localparam logic [2:0] CFG_FIRST_FRAME  = 3'd6;

  // toc geometry and scale constants
  localparam logic [6:0]  TOC_POINTS = 7'd100;
  localparam logic [6:0]  TOC_LAST   = 7'd99;
  localparam logic [8:0]  TOC_FULL   = 9'd256;
  localparam logic [31:0] MS_PER_SEC = 32'd1000;
  localparam logic [31:0] PCT_SCALE  = 32'd100;

  // reciprocals giving exact 32-bit unsigned division by 1000 and by 100
  localparam logic [31:0] RCP_1000    = 32'h10624DD3;
  localparam int          RCP_1000_SH = 38;
  localparam logic [31:0] RCP_100     = 32'h51EB851F;
  localparam int          RCP_100_SH  = 37;

  // datapath widths
  localparam int DIV_W = 40;
  localparam int DVS_W = 32;
  localparam int POS_W = 55;

  typedef struct packed {
    logic        req_type;
    logic [6:0]  toc_index;
    logic [7:0]  toc_value;
    logic [31:0] seek_ms;
  } in_item_t;

  typedef struct packed {
    logic [30:0] byte_pos;
    logic        pos_valid;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  rate_mode;
    logic [31:0] track_length_ms;
    logic [30:0] file_bytes;
    logic [15:0] bytes_per_frame;
    logic [15:0] ms_per_frame;
    logic [7:0]  tail_tag_bytes;
    logic [30:0] first_frame_at;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

endpackage

@@ sv/mp3sbp_front.sv @@
// front end: accepts requests, drops out-of-range toc writes, two-entry queue
// depends on mp3sbp_pkg
`timescale 1ns / 1ps

module mp3sbp_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  output logic                 full_o,
  input  mp3sbp_pkg::in_item_t in_item_i,
  output logic                 item_valid_o,
  output mp3sbp_pkg::in_item_t item_o,
  input  logic                 item_pop_i
);

  mp3sbp_pkg::in_item_t slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       keep, wr_en, rd_en;

  // a toc write beyond the last point has no effect, so it is not queued
  assign keep   = (in_item_i.req_type == mp3sbp_pkg::REQ_SEEK) ||
                  (in_item_i.toc_index < mp3sbp_pkg::TOC_POINTS);
  assign full_o = (count_q == 2'd2);
  assign wr_en  = push_i && !full_o && keep;
  assign rd_en  = item_pop_i && (count_q != 2'd0);

  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = slot_q[rd_ptr_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_q[wr_ptr_q] <= in_item_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (wr_en) wr_ptr_q <= !wr_ptr_q;
      if (rd_en) rd_ptr_q <= !rd_ptr_q;
      if (wr_en && !rd_en)      count_q <= count_q + 2'd1;
      else if (rd_en && !wr_en) count_q <= count_q - 2'd1;
    end
  end

endmodule

@@ sv/mp3sbp_div.sv @@
// shared restoring divider, one quotient bit per cycle
// depends on mp3sbp_pkg
`timescale 1ns / 1ps

module mp3sbp_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mp3sbp_pkg::div_req_t req_i,
  output mp3sbp_pkg::div_rsp_t rsp_o
);

  logic [mp3sbp_pkg::DIV_W-1:0] quo_q;
  logic [mp3sbp_pkg::DVS_W-1:0] rem_q, dvs_q;
  logic [5:0]                   cnt_q;
  logic                         busy_q, done_q;
  logic [mp3sbp_pkg::DVS_W:0]   trial, diff;
  logic                         fits;

  assign trial = {rem_q, quo_q[mp3sbp_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = (trial >= {1'b0, dvs_q});

  // shift and subtract datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[mp3sbp_pkg::DIV_W-2:0], fits};
      rem_q <= fits ? diff[mp3sbp_pkg::DVS_W-1:0] : trial[mp3sbp_pkg::DVS_W-1:0];
    end
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(mp3sbp_pkg::DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

@@ sv/mp3sbp_back.sv @@
// back end: toc memory, seek sequencer around the shared divider, clamp, result register
// depends on mp3sbp_pkg and mp3sbp_div
`timescale 1ns / 1ps

module mp3sbp_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mp3sbp_pkg::cfg_t      cfg_i,
  input  logic                  item_valid_i,
  input  mp3sbp_pkg::in_item_t  item_i,
  output logic                  item_pop_o,
  output logic                  out_valid_o,
  output mp3sbp_pkg::out_item_t out_item_o,
  input  logic                  out_pop_i
);

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_CDIV  = 12'b0000_0000_0010,
    ST_VSECS = 12'b0000_0000_0100,
    ST_VA    = 12'b0000_0000_1000,
    ST_VB    = 12'b0000_0001_0000,
    ST_TPCT  = 12'b0000_0010_0000,
    ST_TREM  = 12'b0000_0100_0000,
    ST_TSL   = 12'b0000_1000_0000,
    ST_TSQ   = 12'b0001_0000_0000,
    ST_TSUM  = 12'b0010_0000_0000,
    ST_CLAMP = 12'b0100_0000_0000,
    ST_FIN   = 12'b1000_0000_0000
  } state_e;

  localparam int PW = mp3sbp_pkg::POS_W;

  state_e state_q, state_d;

  mp3sbp_pkg::div_req_t div_req;
  mp3sbp_pkg::div_rsp_t div_rsp;

  logic [7:0]  toc_mem [mp3sbp_pkg::TOC_POINTS];
  logic [7:0]  cur_q, nxt_q;
  logic        last_q, neg_q;
  logic [31:0] t_q;
  logic [30:0] a_q, base_q;
  logic [22:0] tsec_q;
  logic [31:0] mag_q;
  logic [25:0] q100_q;
  logic [6:0]  rem_q;
  logic [32:0] prod_q;
  logic signed [PW-1:0] pos_q;
  mp3sbp_pkg::out_item_t res_q, out_q;
  logic        out_valid_q;

  logic        mem_we, res_bad, out_load;
  logic [6:0]  pct, pct_nxt;
  logic [22:0] step;
  logic [8:0]  nxt9, diff_mag;
  logic        diff_neg;

  logic [31:0] rcp_in;
  logic [63:0] k1000_prod, k100_prod;
  logic [22:0] secs;
  logic [25:0] q100;

  logic [47:0] cbr_prod;
  logic [53:0] vbr_prod;
  logic [31:0] mag_prod;
  logic [30:0] base_prod;
  logic [32:0] sq_prod;
  logic signed [PW-1:0] sum_pos, lim_w, ffa_w, clamp_pos;
  logic signed [32:0]   lim33;

  mp3sbp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // toc point lookup: percent clamped to the last point
  assign pct     = (div_rsp.quot > 40'(mp3sbp_pkg::TOC_LAST)) ? mp3sbp_pkg::TOC_LAST
                                                              : div_rsp.quot[6:0];
  assign pct_nxt = (pct == mp3sbp_pkg::TOC_LAST) ? pct : pct + 7'd1;

  // interpolation terms
  assign step     = cfg_i.file_bytes[30:8];
  assign nxt9     = last_q ? mp3sbp_pkg::TOC_FULL : {1'b0, nxt_q};
  assign diff_neg = (nxt9 < {1'b0, cur_q});
  assign diff_mag = diff_neg ? ({1'b0, cur_q} - nxt9) : (nxt9 - {1'b0, cur_q});

  // whole seconds by reciprocal: track length first, then seek time
  assign rcp_in     = (state_q == ST_VSECS) ? cfg_i.track_length_ms : t_q;
  assign k1000_prod = 64'(rcp_in) * 64'(mp3sbp_pkg::RCP_1000);
  assign secs       = k1000_prod[mp3sbp_pkg::RCP_1000_SH +: 23];

  // slope step over 100 by reciprocal
  assign k100_prod = 64'(mag_q) * 64'(mp3sbp_pkg::RCP_100);
  assign q100      = k100_prod[mp3sbp_pkg::RCP_100_SH +: 26];

  // multipliers, each feeding a register
  assign cbr_prod  = div_rsp.quot[31:0] * cfg_i.bytes_per_frame;
  assign vbr_prod  = a_q * tsec_q;
  assign mag_prod  = diff_mag * step;
  assign base_prod = step * cur_q;
  assign sq_prod   = q100_q * rem_q;

  assign sum_pos = neg_q ? ($signed(PW'(base_q)) - $signed(PW'(prod_q)))
                         : ($signed(PW'(base_q)) + $signed(PW'(prod_q)));

  // keep clear of the trailing tag and of the header area
  assign lim33     = $signed({2'b00, cfg_i.file_bytes}) - $signed({25'd0, cfg_i.tail_tag_bytes});
  assign lim_w     = PW'(lim33);
  assign ffa_w     = $signed(PW'(cfg_i.first_frame_at));
  assign clamp_pos = (pos_q >= lim_w) ? (lim_w - PW'(1))
                   : ((pos_q < ffa_w) ? ffa_w : pos_q);

  assign out_load = (state_q == ST_FIN) && (!out_valid_q || out_pop_i);

  // sequencer
  always_comb begin
    state_d    = state_q;
    item_pop_o = 1'b0;
    mem_we     = 1'b0;
    res_bad    = 1'b0;
    div_req    = '0;
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          if (item_i.req_type == mp3sbp_pkg::REQ_TOC) begin
            mem_we = 1'b1;
          end else begin
            case (cfg_i.rate_mode)
              mp3sbp_pkg::MODE_CBR: begin
                if (cfg_i.bytes_per_frame == '0 || cfg_i.ms_per_frame == '0) begin
                  res_bad = 1'b1;
                  state_d = ST_FIN;
                end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = 40'(item_i.seek_ms);
                  div_req.divisor  = 32'(cfg_i.ms_per_frame);
                  state_d          = ST_CDIV;
                end
              end
              mp3sbp_pkg::MODE_VBR: begin
                // under one whole second of track there is no estimate
                if (cfg_i.track_length_ms < mp3sbp_pkg::MS_PER_SEC) begin
                  res_bad = 1'b1;
                  state_d = ST_FIN;
                end else begin
                  state_d = ST_VSECS;
                end
              end
              default: begin
                if (cfg_i.track_length_ms == '0) begin
                  res_bad = 1'b1;
                  state_d = ST_FIN;
                end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = 40'(item_i.seek_ms) * 40'(mp3sbp_pkg::PCT_SCALE);
                  div_req.divisor  = cfg_i.track_length_ms;
                  state_d          = ST_TPCT;
                end
              end
            endcase
          end
        end
      end
      ST_CDIV: begin
        if (div_rsp.done) state_d = ST_CLAMP;
      end
      ST_VSECS: begin
        div_req.start    = 1'b1;
        div_req.dividend = 40'(cfg_i.file_bytes);
        div_req.divisor  = 32'(secs);
        state_d          = ST_VA;
      end
      ST_VA: begin
        if (div_rsp.done) state_d = ST_VB;
      end
      ST_VB: begin
        state_d = ST_CLAMP;
      end
      ST_TPCT: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = 40'(div_rsp.rem) * 40'(mp3sbp_pkg::PCT_SCALE);
          div_req.divisor  = cfg_i.track_length_ms;
          state_d          = ST_TREM;
        end
      end
      ST_TREM: begin
        if (div_rsp.done) state_d = ST_TSL;
      end
      ST_TSL: begin
        state_d = ST_TSQ;
      end
      ST_TSQ: begin
        state_d = ST_TSUM;
      end
      ST_TSUM: begin
        state_d = ST_CLAMP;
      end
      ST_CLAMP: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // toc memory write and registered two-point read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      toc_mem[item_i.toc_index] <= item_i.toc_value;
    end
    if (state_q == ST_TPCT && div_rsp.done) begin
      cur_q  <= toc_mem[pct];
      nxt_q  <= toc_mem[pct_nxt];
      last_q <= (pct == mp3sbp_pkg::TOC_LAST);
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && item_valid_i) t_q <= item_i.seek_ms;
    if (res_bad) res_q <= '0;
    case (state_q)
      ST_CDIV:  if (div_rsp.done) pos_q <= $signed(PW'(cbr_prod));
      ST_VA: begin
        if (div_rsp.done) begin
          a_q    <= div_rsp.quot[30:0];
          tsec_q <= secs;
        end
      end
      ST_VB:    pos_q <= $signed(PW'(vbr_prod));
      ST_TREM: begin
        if (div_rsp.done) begin
          rem_q  <= div_rsp.quot[6:0];
          mag_q  <= mag_prod;
          neg_q  <= diff_neg;
          base_q <= base_prod;
        end
      end
      ST_TSL:   q100_q <= q100;
      ST_TSQ:   prod_q <= sq_prod;
      ST_TSUM:  pos_q <= sum_pos;
      ST_CLAMP: begin
        res_q.pos_valid <= !clamp_pos[PW-1];
        res_q.byte_pos  <= clamp_pos[PW-1] ? 31'd0 : clamp_pos[30:0];
      end
      default: ;
    endcase
    if (out_load) out_q <= res_q;
  end

  // control state and result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load)       out_valid_q <= 1'b1;
      else if (out_pop_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

@@ sv/mp3_seek_byte_position.sv @@
// top level of the mp3 seek byte position block: configuration registers and wiring
// depends on mp3sbp_pkg, mp3sbp_front, mp3sbp_back (and mp3sbp_div below it)
`timescale 1ns / 1ps

// Requests enter through a two-entry queue (push/full) and results leave through a
// result register (empty/pop); a waiting result does not stop new requests being
// queued until the queue fills. A request is registered in the queue before the back
// end takes it. A toc write is then stored while the back end stays idle.
// Divisions by a configured value run on one shared 40-step restoring divider, while
// divisions by 100 and 1000 are reciprocal multiplications. A seek, with constant or
// variable bitrate and with or without toc, holds the back end until its final state
// loads the result register, also when no estimate is possible, and while an unread
// result sits there the back end waits in that final state. Configuration writes are
// always ready and must only be issued while no request is in flight.
module mp3_seek_byte_position (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  mp3sbp_pkg::in_item_t  in_item_i,
  output logic                  empty,
  input  logic                  pop,
  output mp3sbp_pkg::out_item_t out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [2:0]            cfg_index_i,
  input  logic [31:0]           cfg_data_i
);

  mp3sbp_pkg::cfg_t     cfg_q;
  mp3sbp_pkg::in_item_t item;
  logic                 item_valid, item_pop, out_valid;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mp3sbp_pkg::CFG_RATE_MODE:   cfg_q.rate_mode       <= cfg_data_i[1:0];
        mp3sbp_pkg::CFG_TRACK_LEN:   cfg_q.track_length_ms <= cfg_data_i;
        mp3sbp_pkg::CFG_FILE_BYTES:  cfg_q.file_bytes      <= cfg_data_i[30:0];
        mp3sbp_pkg::CFG_BYTES_FRAME: cfg_q.bytes_per_frame <= cfg_data_i[15:0];
        mp3sbp_pkg::CFG_MS_FRAME:    cfg_q.ms_per_frame    <= cfg_data_i[15:0];
        mp3sbp_pkg::CFG_TAIL_TAG:    cfg_q.tail_tag_bytes  <= cfg_data_i[7:0];
        mp3sbp_pkg::CFG_FIRST_FRAME: cfg_q.first_frame_at  <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  mp3sbp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .in_item_i    (in_item_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  mp3sbp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .out_valid_o  (out_valid),
    .out_item_o   (out_item_o),
    .out_pop_i    (pop)
  );

  assign empty = !out_valid;

endmodule
